// ===== hw/rtl/cat_pkg.sv =====
// Shared types and constants for the common-anode transpose update block.
// No dependencies; imported by every module of the block.
`default_nettype none

package cat_pkg;

    // width of one segment pattern and of one transposed row word
    localparam int SEG_W = 16;
    // width of one field of the segment remap register
    localparam int MAP_FIELD_W = 4;
    localparam int MAP_W = SEG_W * MAP_FIELD_W;
    localparam int COL_W = 5;

    // configuration reset values
    localparam logic [COL_W-1:0] COLUMN_COUNT_RESET = 5'd8;
    localparam logic             MAP_ENABLE_RESET   = 1'b0;
    localparam logic [MAP_W-1:0] SEGMENT_MAP_RESET  = 64'hFEDC_BA98_7654_3210;

    // configuration register indexes
    localparam logic [1:0] REG_COLUMN_COUNT = 2'd0;
    localparam logic [1:0] REG_MAP_ENABLE   = 2'd1;
    localparam logic [1:0] REG_SEGMENT_MAP  = 2'd2;

    // request function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef struct packed {
        logic             func;
        logic [3:0]       position;
        logic [SEG_W-1:0] pattern;
    } cat_in_t;

    typedef struct packed {
        logic [3:0]       row_index;
        logic [SEG_W-1:0] row_word;
        logic             last;
    } cat_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cat_remap.sv =====
// Segment remap unit: moves each set input bit to the target bit its map field names.
// Depends on cat_pkg.
`default_nettype none

module cat_remap (
    input  wire logic                      enable,
    input  wire logic [cat_pkg::MAP_W-1:0] seg_map,
    input  wire logic [cat_pkg::SEG_W-1:0] pattern,
    output logic      [cat_pkg::SEG_W-1:0] remapped
);
    import cat_pkg::*;

    logic [SEG_W-1:0] mapped;

    // one target decoder per input bit, results ored together
    always_comb
    begin
        mapped = '0;
        for (int n = 0; n < SEG_W; n++)
        begin
            if (pattern[n])
            begin
                mapped[seg_map[n*MAP_FIELD_W +: MAP_FIELD_W]] = 1'b1;
            end
        end
    end

    assign remapped = enable ? mapped : pattern;

endmodule

`default_nettype wire

// ===== hw/rtl/cat_transpose.sv =====
// Row gather unit: collects one segment row's bit from every position into a word.
// Shared across all rows by the sequencer. Depends on cat_pkg.
`default_nettype none

module cat_transpose #(
    parameter int NUM_POSITIONS = 16
) (
    input  wire logic [NUM_POSITIONS-1:0][cat_pkg::SEG_W-1:0] store,
    input  wire logic [3:0]                                    row,
    input  wire logic [cat_pkg::COL_W-1:0]                     column_count,
    output logic      [cat_pkg::SEG_W-1:0]                     word
);
    import cat_pkg::*;

    // positions beyond the store or the column count read as zero
    for (genvar p = 0; p < SEG_W; p++)
    begin : g_col
        if (p < NUM_POSITIONS)
        begin : g_used
            assign word[p] = store[p][row] & (COL_W'(p) < column_count);
        end
        else
        begin : g_unused
            assign word[p] = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/common_anode_transpose_update_core.sv =====
// Common-anode transpose update core: pattern store, sequencer and config registers.
// Sequence: request accepted in idle, then the update state, then a scan of the rows up to
// the last changed one; the row gather unit visits one row per cycle, and a stalled row
// word holds the scan for as long as it waits. A new request is taken only in idle; clear,
// ignored and unchanged requests return to idle straight from the update state.
// Reset: asynchronous, active low; store cleared, registers to defaults.
// Depends on cat_pkg, cat_remap, cat_transpose.
`default_nettype none

module common_anode_transpose_update_core #(
    parameter int NUM_POSITIONS = 16,
    parameter int ROW_COUNT     = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // request channel
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire cat_pkg::cat_in_t item,
    // row word channel
    output logic                  row_valid,
    input  wire logic             row_ready,
    output cat_pkg::cat_out_t     row,
    // configuration port
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [4:0]       paddr,
    input  wire logic [63:0]      pwdata,
    output logic      [63:0]      prdata,
    output logic                  pready
);
    import cat_pkg::*;

    localparam logic [SEG_W-1:0] ROW_MASK = SEG_W'((32'd1 << ROW_COUNT) - 32'd1);
    localparam logic [3:0]       LAST_ROW = 4'(ROW_COUNT - 1);
    localparam logic [4:0]       POS_LIM  = 5'(NUM_POSITIONS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN
    } state_t;

    state_t                              state_reg;
    cat_in_t                             item_reg;
    logic [NUM_POSITIONS-1:0][SEG_W-1:0] store_reg;
    logic [SEG_W-1:0]                    changed_reg;
    logic [3:0]                          row_reg;
    logic                                row_valid_reg;
    cat_out_t                            row_out_reg;
    logic [COL_W-1:0]                    column_count_reg;
    logic                                map_enable_reg;
    logic [MAP_W-1:0]                    segment_map_reg;

    logic [SEG_W-1:0] new_pattern;
    logic [SEG_W-1:0] old_pattern;
    logic [SEG_W-1:0] row_word;
    logic [SEG_W-1:0] above_mask;
    logic             last_row;
    logic             out_free;
    logic             row_load;
    logic             cfg_write;

    // remap of the incoming pattern
    cat_remap u_remap (
        .enable   (map_enable_reg),
        .seg_map  (segment_map_reg),
        .pattern  (item_reg.pattern),
        .remapped (new_pattern)
    );

    // shared row gather unit
    cat_transpose #(
        .NUM_POSITIONS (NUM_POSITIONS)
    ) u_transpose (
        .store        (store_reg),
        .row          (row_reg),
        .column_count (column_count_reg),
        .word         (row_word)
    );

    // old pattern at the addressed position
    always_comb
    begin
        old_pattern = '0;
        for (int i = 0; i < NUM_POSITIONS; i++)
        begin
            if (item_reg.position == 4'(i))
            begin
                old_pattern = store_reg[i];
            end
        end
    end

    // no changed row left above the current one
    assign above_mask = SEG_W'(~((17'd2 << row_reg) - 17'd1));
    assign last_row   = ((changed_reg & above_mask) == '0);
    assign out_free   = !row_valid_reg || row_ready;
    assign row_load   = (state_reg == ST_SCAN) && changed_reg[row_reg] && out_free;

    // sequencer, pattern store and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            item_reg      <= '0;
            store_reg     <= '0;
            row_valid_reg <= 1'b0;
            row_out_reg   <= '0;
            changed_reg   <= '0;
            row_reg       <= '0;
        end
        else
        begin
            // output register filled by the scan, emptied when taken
            if (row_load)
            begin
                row_valid_reg <= 1'b1;
            end
            else if (row_ready)
            begin
                row_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        item_reg  <= item;
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    if (item_reg.func == FUNC_CLEAR)
                    begin
                        store_reg <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else if ({1'b0, item_reg.position} >= POS_LIM)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        for (int i = 0; i < NUM_POSITIONS; i++)
                        begin
                            if (item_reg.position == 4'(i))
                            begin
                                store_reg[i] <= new_pattern;
                            end
                        end
                        changed_reg <= (old_pattern ^ new_pattern) & ROW_MASK;
                        row_reg     <= '0;
                        if (((old_pattern ^ new_pattern) & ROW_MASK) == '0)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (changed_reg[row_reg])
                    begin
                        if (out_free)
                        begin
                            row_out_reg.row_index <= row_reg;
                            row_out_reg.row_word  <= row_word;
                            row_out_reg.last      <= last_row;
                            if (last_row || row_reg == LAST_ROW)
                            begin
                                state_reg <= ST_IDLE;
                            end
                            else
                            begin
                                row_reg <= row_reg + 4'd1;
                            end
                        end
                    end
                    else if (row_reg == LAST_ROW)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        row_reg <= row_reg + 4'd1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign item_ready = (state_reg == ST_IDLE);
    assign row_valid  = row_valid_reg;
    assign row        = row_out_reg;

    // configuration registers
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= COLUMN_COUNT_RESET;
            map_enable_reg   <= MAP_ENABLE_RESET;
            segment_map_reg  <= SEGMENT_MAP_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[4:3])
                REG_COLUMN_COUNT: column_count_reg <= pwdata[COL_W-1:0];
                REG_MAP_ENABLE:   map_enable_reg   <= pwdata[0];
                REG_SEGMENT_MAP:  segment_map_reg  <= pwdata;
                default:          ;
            endcase
        end
    end

    // configuration readback
    always_comb
    begin
        case (paddr[4:3])
            REG_COLUMN_COUNT: prdata = {59'd0, column_count_reg};
            REG_MAP_ENABLE:   prdata = {63'd0, map_enable_reg};
            REG_SEGMENT_MAP:  prdata = segment_map_reg;
            default:          prdata = '0;
        endcase
    end

    // a row word is only loaded by the row scan
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(row_valid_reg) |-> $past(state_reg == ST_SCAN))
    else $error("row word loaded outside row scan");

    // emitted rows stay below the row count
    assert property (@(posedge clk) disable iff (!rst_n)
        row_valid_reg |-> (row_out_reg.row_index <= LAST_ROW))
    else $error("row index beyond row count");

    // an accepted request always goes to the update step
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> (state_reg == ST_UPDATE))
    else $error("accepted request did not reach update");

endmodule

`default_nettype wire

// ===== tb/cat_transpose_checker.sv =====
// Row word checker for the common-anode transpose update core.
// Watches the config port and both channels, predicts row words and compares them.
// Depends on cat_pkg.
module cat_transpose_checker #(
    parameter int NUM_POSITIONS = 16,
    parameter int ROW_COUNT     = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire logic              item_ready,
    input  wire cat_pkg::cat_in_t  item,
    input  wire logic              row_valid,
    input  wire logic              row_ready,
    input  wire cat_pkg::cat_out_t row,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [63:0]       pwdata,
    input  wire logic              pready,
    output int                     fail_count,
    output int                     rows_pending
);

    import cat_pkg::*;

    // shadow of the pattern store and the config registers
    logic [SEG_W-1:0] seg_store [16];
    logic [COL_W-1:0] col_setting;
    logic             remap_on;
    logic [MAP_W-1:0] remap_fields;

    // row words still owed by the block, oldest first
    cat_out_t         rows_due [$];
    cat_out_t         want;
    int               mismatches;

    // each set input bit lands on the bit its map field names; collisions OR together
    function automatic logic [SEG_W-1:0] remap_segments(input logic [SEG_W-1:0] pat);
        logic [SEG_W-1:0] res;
        res = '0;
        for (int n = 0; n < SEG_W; n++)
            if (pat[n])
                res[remap_fields[MAP_FIELD_W*n +: MAP_FIELD_W]] = 1'b1;
        return res;
    endfunction

    // store update and the transposed words of every changed row
    task automatic apply_update(input cat_in_t req);
        logic [SEG_W-1:0] pat;
        logic [SEG_W-1:0] changed;
        int               width;
        int               final_row;
        cat_out_t         word;
        if (req.func == FUNC_CLEAR)
        begin
            for (int p = 0; p < 16; p++)
                seg_store[p] = '0;
        end
        else if (req.position < NUM_POSITIONS)
        begin
            pat = remap_on ? remap_segments(req.pattern) : req.pattern;
            changed = seg_store[req.position] ^ pat;
            seg_store[req.position] = pat;
            width = (col_setting > 16) ? 16 : int'(col_setting);
            final_row = -1;
            for (int r = 0; r < ROW_COUNT && r < SEG_W; r++)
                if (changed[r])
                    final_row = r;
            for (int r = 0; r <= final_row; r++)
            begin
                if (changed[r])
                begin
                    word.row_index = 4'(r);
                    word.row_word = '0;
                    for (int p = 0; p < width && p < NUM_POSITIONS; p++)
                        word.row_word[p] = seg_store[p][r];
                    word.last = (r == final_row);
                    rows_due.push_back(word);
                end
            end
        end
    endtask

    task automatic check_field(input string field, input logic [SEG_W-1:0] want_v,
                               input logic [SEG_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < 16; p++)
                seg_store[p] = '0;
            col_setting = COLUMN_COUNT_RESET;
            remap_on = MAP_ENABLE_RESET;
            remap_fields = SEGMENT_MAP_RESET;
            rows_due.delete();
            mismatches = 0;
            fail_count <= 0;
            rows_pending <= 0;
        end
        else
        begin
            // register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:3])
                    REG_COLUMN_COUNT: col_setting = pwdata[COL_W-1:0];
                    REG_MAP_ENABLE:   remap_on = pwdata[0];
                    REG_SEGMENT_MAP:  remap_fields = pwdata[MAP_W-1:0];
                    default: ;
                endcase
            end
            // row words against the oldest expectation
            if (row_valid && row_ready)
            begin
                if (rows_due.size() == 0)
                begin
                    $display("%0t: unexpected row word, expected none, actual row %0d word %h last %b",
                             $time, row.row_index, row.row_word, row.last);
                    mismatches++;
                end
                else
                begin
                    want = rows_due.pop_front();
                    check_field("row_index", 16'(want.row_index), 16'(row.row_index));
                    check_field("row_word", want.row_word, row.row_word);
                    check_field("last", 16'(want.last), 16'(row.last));
                end
            end
            // accepted requests
            if (item_valid && item_ready)
                apply_update(item);
            fail_count <= mismatches;
            rows_pending <= rows_due.size();
        end
    end

endmodule

// ===== tb/tb_common_anode_transpose_update_core.sv =====
// Testbench top for common_anode_transpose_update_core: clock, reset, request and
// config stimulus, row channel back-pressure and the verdict.
// Depends on cat_pkg, the core and cat_transpose_checker.
module tb_common_anode_transpose_update_core;

    import cat_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_ITEMS   = 82;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    cat_in_t     item       = '0;
    logic        row_valid;
    logic        row_ready  = 1'b0;
    cat_out_t    row;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [4:0]  paddr      = '0;
    logic [63:0] pwdata     = '0;
    logic [63:0] prdata;
    logic        pready;

    int          fail_count;
    int          rows_pending;
    bit          idling     = 1'b1;
    int          stall_left = 0;
    int          cycles     = 0;
    cat_in_t     prev_req   = '0;

    common_anode_transpose_update_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .row_valid  (row_valid),
        .row_ready  (row_ready),
        .row        (row),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    cat_transpose_checker row_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .row_valid    (row_valid),
        .row_ready    (row_ready),
        .row          (row),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .fail_count   (fail_count),
        .rows_pending (rows_pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // row channel back-pressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            row_ready <= 1'b0;
        end
        else if (idling && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 8);
            row_ready <= 1'b0;
        end
        else
            row_ready <= 1'b1;
    end

    // one request; valid stays up afterwards unless a gap or a drain lowers it
    task automatic send_request(input cat_in_t req);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= req;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    task automatic send_write(input logic [3:0] pos, input logic [SEG_W-1:0] pat);
        send_request('{func: FUNC_WRITE, position: pos, pattern: pat});
    endtask

    // stop sending, wait until every row word is in, then let the core go idle
    task automatic wait_rows_drained(input int extra);
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (rows_pending != 0);
        repeat (extra) @(posedge clk);
    endtask

    // setup then access; psel stays up so writes can follow back to back
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    task automatic configure(input logic [COL_W-1:0] cols, input logic map_on,
                             input logic [MAP_W-1:0] map_bits);
        wait_rows_drained(SETTLE_CYCLES);
        write_reg(REG_COLUMN_COUNT, 64'(cols));
        write_reg(REG_MAP_ENABLE, 64'(map_on));
        write_reg(REG_SEGMENT_MAP, map_bits);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic random_config();
        logic [COL_W-1:0] cols;
        logic [MAP_W-1:0] map_bits;
        case ($urandom_range(0, 5))
            0: cols = 5'd0;
            1: cols = 5'd1;
            2: cols = 5'd16;
            3: cols = 5'd31;
            default: cols = COL_W'($urandom_range(1, 16));
        endcase
        if ($urandom_range(0, 3) == 0)
            map_bits = SEGMENT_MAP_RESET;
        else
            map_bits = {$urandom, $urandom};
        configure(cols, 1'($urandom), map_bits);
    endtask

    function automatic logic [SEG_W-1:0] pick_pattern();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return SEG_W'(1) << $urandom_range(0, SEG_W - 1);
            default: return SEG_W'($urandom);
        endcase
    endfunction

    // random writes, a few clears and repeats; halfway the sender holds off until drained
    task automatic run_phase(input int count);
        cat_in_t req;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 15))
                0: req = '{func: FUNC_CLEAR, position: 4'($urandom), pattern: 16'($urandom)};
                1, 2:
                begin
                    req = prev_req;
                    req.func = FUNC_WRITE;
                end
                default: req = '{func: FUNC_WRITE, position: 4'($urandom),
                                 pattern: pick_pattern()};
            endcase
            if (i == count / 2)
                wait_rows_drained(0);
            send_request(req);
            prev_req = req;
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: eight columns, no remap
        send_write(4'd0, 16'hFFFF);
        send_write(4'd15, 16'hFFFF);
        send_write(4'd7, 16'h8001);
        send_write(4'd0, 16'hFFFF);
        send_write(4'd0, 16'h0000);
        send_write(4'd3, 16'hAAAA);
        send_write(4'd3, 16'h5555);
        send_request('{func: FUNC_CLEAR, position: 4'd15, pattern: 16'hFFFF});
        send_write(4'd5, 16'h0001);

        // every input bit folded onto segment zero
        configure(5'd16, 1'b1, 64'h0);
        send_write(4'd1, 16'hFFFF);
        send_write(4'd1, 16'h0000);
        send_write(4'd15, 16'h8000);

        // zero columns, reversed segment order
        configure(5'd0, 1'b1, 64'h0123_4567_89AB_CDEF);
        send_write(4'd2, 16'h0001);
        send_write(4'd2, 16'hF0F0);
        send_request('{func: FUNC_CLEAR, position: 4'd0, pattern: 16'h0000});
        send_write(4'd15, 16'hFFFF);

        // column count past the store, map register all ones but unused
        configure(5'd31, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_write(4'd15, 16'hFFFF);
        send_write(4'd9, 16'h1234);

        // one column, everything onto segment fifteen
        configure(5'd1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_write(4'd0, 16'h00FF);
        send_write(4'd0, 16'hFF00);
        send_request('{func: FUNC_CLEAR, position: 4'd7, pattern: 16'h5A5A});

        // random phases, the last without idling
        for (int ph = 0; ph < 5; ph++)
        begin
            random_config();
            if (ph == 4)
                idling <= 1'b0;
            run_phase(PHASE_ITEMS);
        end

        wait_rows_drained(SETTLE_CYCLES);
        if (fail_count == 0 && rows_pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
